// ===== src/deque_with_count_and_index_query_top_defines.svh =====
// assertion macros used by the deque back end
`ifndef DEQUE_WITH_COUNT_AND_INDEX_QUERY_TOP_DEFINES_SVH
`define DEQUE_WITH_COUNT_AND_INDEX_QUERY_TOP_DEFINES_SVH

// same-cycle implication, quiet while reset is held
`define DEQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// next-cycle implication, quiet while reset is held
`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

// ===== src/deq_pkg.sv =====
// types and constants shared by the deque modules
package deq_pkg;

    localparam int DEPTH_DEFAULT = 256;
    localparam int CMD_Q_DEPTH   = 2;
    localparam int VALUE_W       = 32;
    localparam int POS_W         = 8;
    localparam int TYPE_W        = 2;

    localparam logic [VALUE_W-1:0] ANSWER_NONE = '1;

    typedef enum logic [TYPE_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_COUNT      = 2'd2,
        OP_READ       = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_READ,
        BK_COUNT
    } t_back_state;

    typedef struct packed {
        t_op                op;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   pos;
    } t_cmd;

endpackage

// ===== src/deq_front.sv =====
// front end: takes a request, decodes it and hands it to the command queue
module deq_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [deq_pkg::TYPE_W-1:0]    i_req_type,
    input  logic signed [deq_pkg::VALUE_W-1:0] i_item_value,
    input  logic [deq_pkg::POS_W-1:0]     i_position,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output deq_pkg::t_cmd                 o_q_cmd
);

    logic          r_valid, n_valid;
    deq_pkg::t_cmd r_cmd, n_cmd;
    deq_pkg::t_op  dec_op;
    logic          accept;

    always_comb begin
        case (i_req_type)
            deq_pkg::OP_PUSH_FRONT: dec_op = deq_pkg::OP_PUSH_FRONT;
            deq_pkg::OP_PUSH_BACK:  dec_op = deq_pkg::OP_PUSH_BACK;
            deq_pkg::OP_COUNT:      dec_op = deq_pkg::OP_COUNT;
            default:                dec_op = deq_pkg::OP_READ;
        endcase
    end

    assign busy     = r_valid & i_q_full;
    assign accept   = start & ~busy;
    assign o_q_push = r_valid & ~i_q_full;
    assign o_q_cmd  = r_cmd;

    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (accept) begin
            n_valid   = 1'b1;
            n_cmd.op    = dec_op;
            n_cmd.value = i_item_value;
            n_cmd.pos   = i_position;
        end else if (o_q_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

endmodule

// ===== src/deq_cmd_fifo.sv =====
// short command queue between the front end and the executing back end
module deq_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  deq_pkg::t_cmd i_push_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output deq_pkg::t_cmd o_pop_cmd,
    output logic          o_empty
);

    localparam int QD = deq_pkg::CMD_Q_DEPTH;
    localparam int PW = (QD > 1) ? $clog2(QD) : 1;
    localparam int NW = $clog2(QD + 1);

    deq_pkg::t_cmd   r_entry [QD];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [NW-1:0]   r_count, n_count;
    logic            do_push, do_pop;

    assign o_full    = (r_count == NW'(QD));
    assign o_empty   = (r_count == '0);
    assign do_push   = i_push & ~o_full;
    assign do_pop    = i_pop & ~o_empty;
    assign o_pop_cmd = r_entry[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(QD - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(QD - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ===== src/deq_back.sv =====
// back end: ring store, pointers and the sequencer that carries out commands
`include "deque_with_count_and_index_query_top_defines.svh"

module deq_back #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_empty,
    input  deq_pkg::t_cmd                      i_q_cmd,
    output logic                               o_q_pop,
    output logic                               o_valid,
    output logic signed [deq_pkg::VALUE_W-1:0] o_answer,
    output logic [1:0]                         o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int VW = deq_pkg::VALUE_W;

    logic [VW-1:0] r_mem [DEPTH];

    deq_pkg::t_back_state r_state, n_state;
    deq_pkg::t_cmd        r_cmd, n_cmd;
    logic [AW-1:0]        r_front, n_front;
    logic [CW-1:0]        r_fill, n_fill;
    logic [CW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic [VW-1:0]        r_answer, n_answer;
    deq_pkg::t_status     r_status, n_status;
    logic [VW-1:0]        r_rd_data;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic          is_full, pos_ok, match, last, full_reply;
    logic [CW-1:0] cnt_next;

    // front + offset wrapped into the ring, offset below depth
    function automatic logic [AW-1:0] ring(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        begin
            sum = SW'(base) + SW'(off);
            if (sum >= SW'(DEPTH)) begin
                sum = sum - SW'(DEPTH);
            end
            return sum[AW-1:0];
        end
    endfunction

    assign is_full    = (r_fill == CW'(DEPTH));
    assign pos_ok     = (32'(r_cmd.pos) < 32'(r_fill));
    assign match      = (r_rd_data == r_cmd.value);
    assign cnt_next   = r_cnt + CW'(match);
    assign last       = (r_idx == r_fill - 1'b1);
    assign full_reply = r_out_valid & (r_status == deq_pkg::STATUS_FULL);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_front     = r_front;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_out_valid = 1'b0;
        n_answer    = r_answer;
        n_status    = r_status;
        o_q_pop     = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_front;
        rd_en       = 1'b0;
        rd_addr     = r_front;

        case (r_state)
            deq_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_state = deq_pkg::BK_EXEC;
                end
            end
            deq_pkg::BK_EXEC: begin
                case (r_cmd.op)
                    deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
                        n_out_valid = 1'b1;
                        n_answer    = '0;
                        n_state     = deq_pkg::BK_IDLE;
                        if (is_full) begin
                            n_status = deq_pkg::STATUS_FULL;
                        end else begin
                            n_status = deq_pkg::STATUS_OK;
                            wr_en    = 1'b1;
                            n_fill   = r_fill + 1'b1;
                            if (r_cmd.op == deq_pkg::OP_PUSH_FRONT) begin
                                n_front = (r_front == '0) ? AW'(DEPTH - 1)
                                                          : r_front - 1'b1;
                                wr_addr = n_front;
                            end else begin
                                wr_addr = ring(r_front, r_fill);
                            end
                        end
                    end
                    deq_pkg::OP_COUNT: begin
                        if (r_fill == '0) begin
                            n_out_valid = 1'b1;
                            n_answer    = '0;
                            n_status    = deq_pkg::STATUS_OK;
                            n_state     = deq_pkg::BK_IDLE;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_front;
                            n_idx   = '0;
                            n_cnt   = '0;
                            n_state = deq_pkg::BK_COUNT;
                        end
                    end
                    default: begin
                        if (pos_ok) begin
                            rd_en   = 1'b1;
                            rd_addr = ring(r_front, CW'(r_cmd.pos));
                            n_state = deq_pkg::BK_READ;
                        end else begin
                            n_out_valid = 1'b1;
                            n_answer    = deq_pkg::ANSWER_NONE;
                            n_status    = deq_pkg::STATUS_RANGE;
                            n_state     = deq_pkg::BK_IDLE;
                        end
                    end
                endcase
            end
            deq_pkg::BK_READ: begin
                n_out_valid = 1'b1;
                n_answer    = r_rd_data;
                n_status    = deq_pkg::STATUS_OK;
                n_state     = deq_pkg::BK_IDLE;
            end
            deq_pkg::BK_COUNT: begin
                // compare the entry that just came out, fetch the next one unless it was the last
                n_cnt = cnt_next;
                if (last) begin
                    n_out_valid = 1'b1;
                    n_answer    = VW'(cnt_next);
                    n_status    = deq_pkg::STATUS_OK;
                    n_state     = deq_pkg::BK_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = ring(r_front, r_idx + 1'b1);
                end
            end
            default: begin
                n_state = deq_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= deq_pkg::BK_IDLE;
            r_front     <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
        r_cmd    <= n_cmd;
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
        r_answer <= n_answer;
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_cmd.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_valid  = r_out_valid;
    assign o_answer = r_answer;
    assign o_status = r_status;

    `DEQ_ASSERT_NOW(a_fill_bounded, i_clk, i_rst_n, 1'b1, r_fill <= CW'(DEPTH))
    `DEQ_ASSERT_NEXT(a_fill_steps_by_one, i_clk, i_rst_n, 1'b1, r_fill - $past(r_fill) <= CW'(1))
    `DEQ_ASSERT_NOW(a_full_flag_only_when_full, i_clk, i_rst_n, full_reply, is_full)
    `DEQ_ASSERT_NEXT(a_result_then_idle, i_clk, i_rst_n, n_out_valid, r_state == deq_pkg::BK_IDLE)

endmodule

// ===== src/deque_with_count_and_index_query_top.sv =====
// Bounded double-ended queue of signed 32-bit values with count and index queries.
// Requests come in on start/busy: a request is taken at a clock edge where start
// is high and busy is low, with i_req_type, i_item_value and i_position beside it.
// Request kinds: push front, push back, count entries equal to a value, read at a
// zero-based position from the front.
// Each request gives one result on o_answer/o_status, shown for exactly one cycle
// with o_valid high; the receiver cannot stall, so nothing holds results back.
// A two-entry command queue sits between the decoding front end and the back end
// that owns the single-port ring store, so requests queue up while one executes.
// From acceptance to o_valid, a request passes the front-end register, the command
// queue and the back-end command register before its result is registered; a read
// in range also waits for its store read, and a count reads one entry per cycle
// as it walks the entries. The back end carries out one request at a time and pops
// the next only once it is back in idle, so a count holds up the requests behind it.
// Reset (synchronous, active low) empties the queue, clearing valid flags and states;
// the store itself is not cleared and holds no valid data until written.
module deque_with_count_and_index_query_top #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [deq_pkg::TYPE_W-1:0]         i_req_type,
    input  logic signed [deq_pkg::VALUE_W-1:0] i_item_value,
    input  logic [deq_pkg::POS_W-1:0]          i_position,
    output logic                               o_valid,
    output logic signed [deq_pkg::VALUE_W-1:0] o_answer,
    output logic [1:0]                         o_status
);

    logic          q_push, q_full, q_pop, q_empty;
    deq_pkg::t_cmd q_in_cmd, q_out_cmd;

    deq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_item_value (i_item_value),
        .i_position   (i_position),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_cmd      (q_in_cmd)
    );

    deq_cmd_fifo u_cmd_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (q_in_cmd),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_pop_cmd  (q_out_cmd),
        .o_empty    (q_empty)
    );

    deq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_cmd   (q_out_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .o_answer  (o_answer),
        .o_status  (o_status)
    );

endmodule
